@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked assertions; clk and rst come from the module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/abt_pkg.sv @@
// ---------------------------------------------------------------------------
// Arcball tracker package
// Shared constants, codes, request type and product index tables.
// ---------------------------------------------------------------------------
package abt_pkg;

  // Width of the shared divide / square root datapath.
  localparam int DW = 64;
  // Guard bits used in the rim normalization.
  localparam int GUARD = 14;
  // Coordinates are halved until both magnitudes are below 2^RED_BITS.
  localparam int RED_BITS = 17;

  localparam logic [1:0] OP_MOVE    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_RESET   = 2'd3;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

  // Cross and dot product terms: component c, term j.
  function automatic logic [1:0] cross_fi(input logic [1:0] c, input logic [1:0] j);
    logic [1:0] r;
    case ({c, j})
      4'b0000: r = 2'd1;
      4'b0001: r = 2'd2;
      4'b0100: r = 2'd2;
      4'b0101: r = 2'd0;
      4'b1000: r = 2'd0;
      4'b1001: r = 2'd1;
      4'b1100: r = 2'd0;
      4'b1101: r = 2'd1;
      4'b1110: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_ti(input logic [1:0] c, input logic [1:0] j);
    logic [1:0] r;
    case ({c, j})
      4'b0000: r = 2'd2;
      4'b0001: r = 2'd1;
      4'b0100: r = 2'd0;
      4'b0101: r = 2'd2;
      4'b1000: r = 2'd1;
      4'b1001: r = 2'd0;
      4'b1100: r = 2'd0;
      4'b1101: r = 2'd1;
      4'b1110: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic cross_neg(input logic [1:0] c, input logic [1:0] j);
    return (c != 2'd3) && (j == 2'd1);
  endfunction

  // Hamilton product d * a: term j uses d3, d0, d1, d2 in turn.
  function automatic logic [1:0] ham_di(input logic [1:0] j);
    return (j == 2'd0) ? 2'd3 : j - 2'd1;
  endfunction

  function automatic logic [1:0] ham_ai(input logic [1:0] c, input logic [1:0] j);
    logic [1:0] r;
    case (c)
      2'd0:    r = (j == 2'd0) ? 2'd0 : 2'd0 - j;
      2'd1:    r = (j == 2'd3) ? 2'd0 : j + 2'd1;
      2'd2:    r = 2'd2 ^ (2'd0 - j);
      default: r = (j == 2'd0) ? 2'd3 : j - 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic ham_neg(input logic [1:0] c, input logic [1:0] j);
    logic r;
    case (c)
      2'd0:    r = (j == 2'd3);
      2'd1:    r = (j == 2'd1);
      2'd2:    r = (j == 2'd2);
      default: r = (j != 2'd0);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/abt_divsqrt.sv @@
// ---------------------------------------------------------------------------
// Arcball shared divide / square root unit
// Restoring divider, one quotient bit per cycle, or a digit-by-digit
// integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module abt_divsqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  abt_pkg::ds_req_t      req,
  input  logic [abt_pkg::DW-1:0] opa,
  input  logic [abt_pkg::DW-1:0] opb,
  output logic                  done,
  output logic [abt_pkg::DW-1:0] q,
  output logic [abt_pkg::DW-1:0] rem
);
  import abt_pkg::*;

  localparam int CNTW = $clog2(DW + 1);

  logic            busy;
  logic            mode;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   sh;
  logic [DW-1:0]   den;
  logic [DW-1:0]   qr;
  logic [DW:0]     rm;

  logic [DW:0] rm_sh;
  logic [DW:0] rb;

  assign rm_sh = {rm[DW-1:0], sh[DW-1]};
  assign rb    = {1'b0, qr} + {1'b0, sh};
  assign q     = qr;
  assign rem   = rm[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mode <= req.is_sqrt;
        qr   <= '0;
        den  <= opb;
        if (req.is_sqrt) begin
          cnt <= CNTW'(DW / 2);
          rm  <= {1'b0, opa};
          sh  <= DW'(1) << (DW - 2);
        end else begin
          cnt <= CNTW'(DW);
          rm  <= '0;
          sh  <= opa;
        end
      end else if (busy) begin
        if (mode) begin
          // sh holds the trial bit, qr the partial root, rm the remainder.
          if (rm >= rb) begin
            rm <= rm - rb;
            qr <= (qr >> 1) + sh;
          end else begin
            qr <= qr >> 1;
          end
          sh <= sh >> 2;
        end else begin
          if (rm_sh >= {1'b0, den}) begin
            rm <= rm_sh - {1'b0, den};
            qr <= {qr[DW-2:0], 1'b1};
          end else begin
            rm <= rm_sh;
            qr <= {qr[DW-2:0], 1'b0};
          end
          sh <= sh << 1;
        end
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/arcball_rotation_tracker_top.sv @@
// ---------------------------------------------------------------------------
// Arcball rotation tracker
// Pointer events in, current rotation quaternion out, one result per event.
// ---------------------------------------------------------------------------
// Usage: the slave stream carries one pointer event per item, mouse_x and
// mouse_y in tdata and the opcode (move, press, release, reset) in tuser.
// The master stream returns one item per event: rot_x..rot_w in Q2.FRAC_BITS
// in tdata and is_dragging in tuser. Ball center and radius are written
// through the cfg port while the block is idle; they apply from the next
// event on.
// Flow: an event that needs no rotation update (reset, idle move or idle
// release) passes through ST_FINISH to ST_OUT, where its result is
// registered. An event that updates the rotation maps two points onto the
// sphere and then forms the drag and Hamilton products. Most of the work is
// in the shared divide / square root unit: two divisions and at most one
// root per point. One event is in work at a time; the next one can be taken
// in the cycle after the result is registered, which waits for the output
// slot to be free.
// Reset clears the drag, sets both rotations to identity and the config to
// center (0,0), radius 1. A stalled receiver holds the result in the output
// register; the next event is taken and worked on meanwhile.
// ---------------------------------------------------------------------------
module arcball_rotation_tracker_top #(
  parameter int FRAC_BITS   = 14,
  parameter int COORD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  // tdata: mouse_x, mouse_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
  // tuser: opcode
  input  logic [1:0]                           s_tuser,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // tdata: rot_x, rot_y, rot_z, rot_w
  output logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
  // tuser: is_dragging
  output logic                                 m_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [((COORD_WIDTH>16)?COORD_WIDTH:16)-1:0] cfg_data
);
  import abt_pkg::*;

  `include "assert_macros.svh"

  localparam int F   = FRAC_BITS;
  localparam int CW  = COORD_WIDTH;
  localparam int QW  = F + 2;
  localparam int MW  = (QW > RED_BITS + 1) ? QW : RED_BITS + 1;
  localparam int PW  = 2 * MW;
  localparam int ACW = PW + 3;
  localparam int AXW = (CW + 1 > RED_BITS + 1) ? CW + 1 : RED_BITS + 1;
  localparam int LW  = 33;
  localparam int OTW = ((4 * QW + 7) / 8) * 8;

  localparam logic signed [QW-1:0]  ONE_Q   = QW'(1) <<< F;
  localparam logic signed [QW-1:0]  QMAX    = (QW'(1) <<< (F + 1)) - QW'(1);
  localparam logic signed [QW-1:0]  QMIN    = QW'(1) <<< (F + 1);
  localparam logic [ACW-1:0]        ONE_A   = ACW'(1) << F;
  localparam logic [ACW-1:0]        TWO_A   = ACW'(1) << (F + 1);
  localparam logic [ACW-1:0]        QMAX_A  = TWO_A - ACW'(1);
  localparam logic [ACW-1:0]        HALF_A  = ACW'(1) << (F - 1);
  localparam logic signed [ACW-1:0] ONE2_A  = ACW'(1) <<< (2 * F);
  localparam logic [DW-1:0]         ONE_D   = DW'(1) << F;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SPH_START, ST_INSQ, ST_IN_DIVX, ST_IN_DIVY, ST_SQ, ST_IN_SQRT,
    ST_REDUCE, ST_D2, ST_OUT_SQRT, ST_OUT_DIVX, ST_OUT_DIVY, ST_SPH_STORE,
    ST_CROSS, ST_HAM, ST_FINISH, ST_OUT
  } state_t;

  state_t state;
  logic [1:0] op;
  logic       pt;
  logic [1:0] cidx;
  logic [2:0] tidx;
  logic       issued;

  logic signed [CW-1:0] cx, cy, ppx, ppy, evx, evy;
  logic [15:0]          rad;
  logic                 drag;
  logic signed [QW-1:0] rap [4];
  logic signed [QW-1:0] rcur [4];
  logic signed [QW-1:0] fv [3];
  logic signed [QW-1:0] tv [3];
  logic signed [QW-1:0] dv [4];
  logic                 nx, ny;
  logic [AXW-1:0]       ax, ay;
  logic [15:0]          rr;
  logic [F:0]           mxv, myv, mzv;
  logic [LW-1:0]        lenv;
  logic signed [PW-1:0] prod;
  logic                 pneg;
  logic signed [ACW-1:0] acc;
  logic [DW-1:0]        dsa, dsb;

  // Shared divide / square root unit.
  ds_req_t       ds_req;
  logic          ds_done;
  logic [DW-1:0] ds_q, ds_rem;
  logic          ds_wait;

  assign ds_wait = (state == ST_IN_DIVX) || (state == ST_IN_DIVY) ||
                   (state == ST_IN_SQRT) || (state == ST_OUT_SQRT) ||
                   (state == ST_OUT_DIVX) || (state == ST_OUT_DIVY);
  assign ds_req.start   = ds_wait && !issued;
  assign ds_req.is_sqrt = (state == ST_IN_SQRT) || (state == ST_OUT_SQRT);

  abt_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (ds_req),
    .opa  (dsa),
    .opb  (dsb),
    .done (ds_done),
    .q    (ds_q),
    .rem  (ds_rem)
  );

  assign s_tready = (state == ST_IDLE);

  // Point selection and offset from the centre.
  logic signed [CW-1:0] px, py;
  logic signed [CW:0]   sdx, sdy;
  logic [CW:0]          adx, ady;
  logic [15:0]          reff;

  assign px   = pt ? evx : ppx;
  assign py   = pt ? evy : ppy;
  assign sdx  = (CW + 1)'(px) - (CW + 1)'(cx);
  assign sdy  = (CW + 1)'(py) - (CW + 1)'(cy);
  assign adx  = sdx[CW] ? -sdx : sdx;
  assign ady  = sdy[CW] ? -sdy : sdy;
  assign reff = (rad == 16'd0) ? 16'd1 : rad;

  // Multiply-accumulate operand selection.
  logic [2:0]           dot_k;
  logic signed [MW-1:0] op_a, op_b;
  logic                 op_neg;

  always_comb begin
    dot_k  = 3'd0;
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    case (state)
      ST_INSQ: begin
        dot_k = 3'd3;
        case (tidx)
          3'd0: begin
            op_a = MW'(ax[RED_BITS-1:0]);
            op_b = MW'(ax[RED_BITS-1:0]);
          end
          3'd1: begin
            op_a = MW'(ay[RED_BITS-1:0]);
            op_b = MW'(ay[RED_BITS-1:0]);
          end
          3'd2: begin
            op_a   = MW'(rr);
            op_b   = MW'(rr);
            op_neg = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SQ: begin
        dot_k = 3'd2;
        case (tidx)
          3'd0: begin
            op_a = MW'(mxv);
            op_b = MW'(mxv);
          end
          3'd1: begin
            op_a = MW'(myv);
            op_b = MW'(myv);
          end
          default: ;
        endcase
      end
      ST_D2: begin
        dot_k = 3'd2;
        case (tidx)
          3'd0: begin
            op_a = MW'(ax[RED_BITS-1:0]);
            op_b = MW'(ax[RED_BITS-1:0]);
          end
          3'd1: begin
            op_a = MW'(ay[RED_BITS-1:0]);
            op_b = MW'(ay[RED_BITS-1:0]);
          end
          default: ;
        endcase
      end
      ST_CROSS: begin
        dot_k = (cidx == 2'd3) ? 3'd3 : 3'd2;
        if (tidx < dot_k) begin
          op_a   = MW'(fv[cross_fi(cidx, tidx[1:0])]);
          op_b   = MW'(tv[cross_ti(cidx, tidx[1:0])]);
          op_neg = cross_neg(cidx, tidx[1:0]);
        end
      end
      ST_HAM: begin
        dot_k = 3'd4;
        if (tidx < dot_k) begin
          op_a   = MW'(dv[ham_di(tidx[1:0])]);
          op_b   = MW'(rap[ham_ai(cidx, tidx[1:0])]);
          op_neg = ham_neg(cidx, tidx[1:0]);
        end
      end
      default: ;
    endcase
  end

  logic signed [ACW-1:0] acc_sum;
  logic signed [ACW-1:0] prod_x;
  assign prod_x  = ACW'(prod);
  assign acc_sum = (tidx == 3'd0) ? '0 : (pneg ? acc - prod_x : acc + prod_x);

  // Rescale by 2^-F, rounding half away from zero, then clamp.
  logic                 acc_neg;
  logic [ACW-1:0]       acc_mag, rnd;
  logic [QW-1:0]        dmag;
  logic signed [QW-1:0] qd, qrot;

  assign acc_neg = acc_sum[ACW-1];
  assign acc_mag = acc_neg ? -acc_sum : acc_sum;
  assign rnd     = (acc_mag + HALF_A) >> F;
  assign dmag    = (rnd > ONE_A) ? QW'(ONE_A) : rnd[QW-1:0];
  assign qd      = acc_neg ? -dmag : dmag;

  always_comb begin
    if (acc_neg) begin
      qrot = (rnd > TWO_A) ? QMIN : -rnd[QW-1:0];
    end else begin
      qrot = (rnd > QMAX_A) ? QMAX : rnd[QW-1:0];
    end
  end

  logic [F:0] sq_near, q_clamp;
  assign sq_near = (ds_rem > ds_q) ? ds_q[F:0] + (F + 1)'(1) : ds_q[F:0];
  assign q_clamp = (ds_q > ONE_D) ? ONE_D[F:0] : ds_q[F:0];

  logic dot_end;
  assign dot_end = (tidx == dot_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issued   <= 1'b0;
      tidx     <= '0;
      cidx     <= '0;
      pt       <= 1'b0;
      cx       <= '0;
      cy       <= '0;
      rad      <= 16'd1;
      drag     <= 1'b0;
      ppx      <= '0;
      ppy      <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        rap[i]  <= (i == 3) ? ONE_Q : '0;
        rcur[i] <= (i == 3) ? ONE_Q : '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X: cx  <= cfg_data[CW-1:0];
          REG_CENTER_Y: cy  <= cfg_data[CW-1:0];
          REG_RADIUS:   rad <= cfg_data[15:0];
          default: ;
        endcase
      end

      // In ST_OUT the output register is refilled instead.
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end

      prod <= op_a * op_b;
      pneg <= op_neg;
      if ((state == ST_INSQ) || (state == ST_SQ) || (state == ST_D2) ||
          (state == ST_CROSS) || (state == ST_HAM)) begin
        acc  <= acc_sum;
        tidx <= dot_end ? 3'd0 : tidx + 3'd1;
      end

      if (ds_wait) begin
        if (!issued) begin
          issued <= 1'b1;
        end else if (ds_done) begin
          issued <= 1'b0;
        end
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op  <= s_tuser;
            evx <= s_tdata[CW-1:0];
            evy <= s_tdata[2*CW-1:CW];
            pt  <= 1'b0;
            case (s_tuser)
              OP_MOVE, OP_RELEASE: begin
                state <= drag ? ST_SPH_START : ST_FINISH;
              end
              OP_PRESS: begin
                drag  <= 1'b1;
                ppx   <= s_tdata[CW-1:0];
                ppy   <= s_tdata[2*CW-1:CW];
                state <= ST_SPH_START;
              end
              default: begin
                drag <= 1'b0;
                ppx  <= cx;
                ppy  <= cy;
                for (int i = 0; i < 4; i++) begin
                  rap[i]  <= (i == 3) ? ONE_Q : '0;
                  rcur[i] <= (i == 3) ? ONE_Q : '0;
                end
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SPH_START: begin
          ax   <= AXW'(adx);
          ay   <= AXW'(ady);
          nx   <= sdx[CW];
          ny   <= sdy[CW];
          rr   <= reff;
          tidx <= '0;
          // The exact circle test needs the squares only once both offsets are in range.
          state <= ((AXW'(adx) <= AXW'(reff)) && (AXW'(ady) <= AXW'(reff))) ?
                   ST_INSQ : ST_REDUCE;
        end
        ST_INSQ: begin
          if (dot_end) begin
            dsa   <= (DW'(ax[15:0]) << F) + DW'(rr[15:1]);
            dsb   <= DW'(rr);
            state <= (acc_sum <= 0) ? ST_IN_DIVX : ST_REDUCE;
          end
        end
        ST_IN_DIVX: begin
          if (issued && ds_done) begin
            mxv   <= ds_q[F:0];
            dsa   <= (DW'(ay[15:0]) << F) + DW'(rr[15:1]);
            state <= ST_IN_DIVY;
          end
        end
        ST_IN_DIVY: begin
          if (issued && ds_done) begin
            myv   <= ds_q[F:0];
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (dot_end) begin
            if (acc_sum >= ONE2_A) begin
              mzv   <= '0;
              state <= ST_SPH_STORE;
            end else begin
              dsa   <= DW'(ONE2_A - acc_sum);
              state <= ST_IN_SQRT;
            end
          end
        end
        ST_IN_SQRT: begin
          if (issued && ds_done) begin
            mzv   <= sq_near;
            state <= ST_SPH_STORE;
          end
        end
        ST_REDUCE: begin
          if ((|ax[AXW-1:RED_BITS]) || (|ay[AXW-1:RED_BITS])) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else begin
            tidx  <= '0;
            state <= ST_D2;
          end
        end
        ST_D2: begin
          if (dot_end) begin
            dsa   <= DW'(acc_sum) << (2 * GUARD);
            state <= ST_OUT_SQRT;
          end
        end
        ST_OUT_SQRT: begin
          if (issued && ds_done) begin
            lenv  <= ds_q[LW-1:0];
            dsa   <= (DW'(ax[RED_BITS-1:0]) << (F + GUARD)) + DW'(ds_q[LW-1:1]);
            dsb   <= DW'(ds_q[LW-1:0]);
            state <= ST_OUT_DIVX;
          end
        end
        ST_OUT_DIVX: begin
          if (issued && ds_done) begin
            mxv   <= q_clamp;
            dsa   <= (DW'(ay[RED_BITS-1:0]) << (F + GUARD)) + DW'(lenv[LW-1:1]);
            state <= ST_OUT_DIVY;
          end
        end
        ST_OUT_DIVY: begin
          if (issued && ds_done) begin
            myv   <= q_clamp;
            mzv   <= '0;
            state <= ST_SPH_STORE;
          end
        end
        ST_SPH_STORE: begin
          if (pt) begin
            tv[0] <= nx ? -QW'(mxv) : QW'(mxv);
            tv[1] <= ny ? -QW'(myv) : QW'(myv);
            tv[2] <= QW'(mzv);
            cidx  <= '0;
            tidx  <= '0;
            state <= ST_CROSS;
          end else begin
            fv[0] <= nx ? -QW'(mxv) : QW'(mxv);
            fv[1] <= ny ? -QW'(myv) : QW'(myv);
            fv[2] <= QW'(mzv);
            pt    <= 1'b1;
            state <= ST_SPH_START;
          end
        end
        ST_CROSS: begin
          if (dot_end) begin
            dv[cidx] <= qd;
            cidx     <= cidx + 2'd1;
            if (cidx == 2'd3) begin
              state <= ST_HAM;
            end
          end
        end
        ST_HAM: begin
          if (dot_end) begin
            rcur[cidx] <= qrot;
            cidx       <= cidx + 2'd1;
            if (cidx == 2'd3) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (op == OP_RELEASE) begin
            for (int i = 0; i < 4; i++) begin
              rap[i] <= rcur[i];
            end
            drag <= 1'b0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OTW'({rcur[3], rcur[2], rcur[1], rcur[0]});
            m_tuser  <= drag;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(a_busy_after_item, s_tvalid && s_tready, !s_tready, "block took an item while busy")
  `ASSERT_NXT(a_press_drags, s_tvalid && s_tready && (s_tuser == OP_PRESS), drag, "press did not start a drag")
  `ASSERT_NXT(a_reset_identity, s_tvalid && s_tready && (s_tuser == OP_RESET), (rcur[3] == ONE_Q) && !drag, "reset event did not restore identity")
  `ASSERT_IMP(a_ds_done_expected, ds_done, ds_wait && issued, "divide or root finished with nobody waiting")

endmodule
